// ===== src/mbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrm_pkg
// Types, codes and the CRC-16 byte update for the Modbus RTU read engine.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEND  = 4'b0010,
    ST_WORDS = 4'b0100,
    ST_STAT  = 4'b1000
  } state_t;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_TIMEOUT = 3'd1;
  localparam logic [2:0] STS_EXCEPT  = 3'd2;
  localparam logic [2:0] STS_LENGTH  = 3'd3;
  localparam logic [2:0] STS_CRC     = 3'd4;
  localparam logic [2:0] STS_QTY     = 3'd5;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  EXC_BIT   = 8'h80;
  localparam logic [7:0]  HDR_BYTES = 8'd5;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/modbus_rtu_master_read_engine.sv =====
// Unless the output stalls, a request gives 8 result items, one per cycle, and the
// CRC covers the first six frame bytes; the last byte of a good reply is followed by
// n+1 result items (n words read from the word memory, one per cycle, then a status).
// Otherwise a status alone. Word reads are registered and prefetched one word ahead.
// Reset (rst_n low, synchronous): idle, timeout 1000; word memory not cleared.
// ----------------------------------------------------------------------------
// modbus_rtu_master_read_engine
// Modbus RTU master for read holding / input registers: builds the request
// frame, collects the reply, checks it and returns the register words.
// ----------------------------------------------------------------------------
module modbus_rtu_master_read_engine #(
  parameter int MAX_QTY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slave_addr[7:0], function_code[15:8], start_addr[31:16], quantity[37:32],
  // rx_byte[45:38], zero[47:46]
  input  logic [47:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0], reg_index[13:8], reg_value[29:14], status[32:30], zero[39:33]
  output logic [39:0] out_tdata,
  // out_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = (MAX_QTY > 1) ? $clog2(MAX_QTY) : 1;
  localparam logic [6:0] MAXQ = 7'(MAX_QTY);

  mbrm_pkg::state_t state_r, state_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  slave_r, slave_nxt;
  logic [7:0]  sfunc_r, sfunc_nxt;
  logic [15:0] start_r, start_nxt;
  logic [5:0]  sq_r, sq_nxt;
  logic [7:0]  bytes_r, bytes_nxt;
  logic [7:0]  rfunc_r, rfunc_nxt;
  logic [7:0]  rcount_r, rcount_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] timeout_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [5:0]  widx_r, widx_nxt;
  logic [2:0]  sts_r, sts_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_tx_r, out_tx_nxt;
  logic [5:0]  out_idx_r, out_idx_nxt;
  logic [15:0] out_val_r, out_val_nxt;
  logic [2:0]  out_sts_r, out_sts_nxt;
  logic        out_last_r, out_last_nxt;

  logic [15:0] mem [MAX_QTY];
  logic [15:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [15:0]   wr_data;

  logic        in_fire;
  logic        o_free;
  logic [7:0]  f_slave, f_func, f_qty8, f_rx;
  logic [15:0] f_start;
  logic [5:0]  f_qty;
  logic [7:0]  exp_len, exp_m1, exp_m2;
  logic [7:0]  tx_sel;
  logic [7:0]  feed_byte;
  logic [15:0] crc_f;
  logic [31:0] tick_inc;
  logic [6:0]  word_pos;
  logic [5:0]  widx_inc;

  assign f_slave = in_tdata[7:0];
  assign f_func  = in_tdata[15:8];
  assign f_start = in_tdata[31:16];
  assign f_qty   = in_tdata[37:32];
  assign f_rx    = in_tdata[45:38];
  assign f_qty8  = {2'b00, f_qty};

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == mbrm_pkg::ST_IDLE);
  assign o_free    = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign exp_len  = mbrm_pkg::HDR_BYTES + {1'b0, sq_r, 1'b0};
  assign exp_m1   = exp_len - 8'd1;
  assign exp_m2   = exp_len - 8'd2;
  assign tick_inc = tick_r + 32'd1;
  assign word_pos = bytes_r[7:1] - 7'd2;
  assign widx_inc = widx_r + 6'd1;

  always_comb begin
    case (cnt_r)
      3'd0:    tx_sel = slave_r;
      3'd1:    tx_sel = sfunc_r;
      3'd2:    tx_sel = start_r[15:8];
      3'd3:    tx_sel = start_r[7:0];
      3'd4:    tx_sel = 8'h00;
      3'd5:    tx_sel = {2'b00, sq_r};
      3'd6:    tx_sel = crc_r[7:0];
      default: tx_sel = crc_r[15:8];
    endcase
  end

  assign feed_byte = (state_r == mbrm_pkg::ST_SEND) ? tx_sel : f_rx;
  assign crc_f     = mbrm_pkg::crc_feed(crc_r, feed_byte);

  assign wr_addr = AW'(word_pos);
  assign wr_data = {pend_r, f_rx};

  always_comb begin
    if (state_r == mbrm_pkg::ST_WORDS) begin
      if (o_free && (widx_inc < sq_r)) begin
        rd_addr = AW'(widx_inc);
      end else begin
        rd_addr = AW'(widx_r);
      end
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    await_nxt  = await_r;
    slave_nxt  = slave_r;
    sfunc_nxt  = sfunc_r;
    start_nxt  = start_r;
    sq_nxt     = sq_r;
    bytes_nxt  = bytes_r;
    rfunc_nxt  = rfunc_r;
    rcount_nxt = rcount_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    pend_nxt   = pend_r;
    tick_nxt   = tick_r;
    cnt_nxt    = cnt_r;
    widx_nxt   = widx_r;
    sts_nxt    = sts_r;
    mem_we     = 1'b0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_tx_nxt    = out_tx_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_sts_nxt   = out_sts_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      mbrm_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            mbrm_pkg::REQ_START: begin
              if ({1'b0, f_qty} > MAXQ) begin
                await_nxt = 1'b0;
                sts_nxt   = mbrm_pkg::STS_QTY;
                state_nxt = mbrm_pkg::ST_STAT;
              end else begin
                slave_nxt  = f_slave;
                sfunc_nxt  = f_func;
                start_nxt  = f_start;
                sq_nxt     = f_qty;
                bytes_nxt  = 8'd0;
                rfunc_nxt  = 8'd0;
                rcount_nxt = 8'd0;
                crc_nxt    = mbrm_pkg::CRC_INIT;
                crc_lo_nxt = 8'd0;
                pend_nxt   = 8'd0;
                tick_nxt   = 32'd0;
                cnt_nxt    = 3'd0;
                await_nxt  = 1'b1;
                state_nxt  = mbrm_pkg::ST_SEND;
              end
            end
            mbrm_pkg::REQ_TICK: begin
              if (await_r) begin
                tick_nxt = tick_inc;
                if (tick_inc >= timeout_r) begin
                  await_nxt = 1'b0;
                  sts_nxt   = mbrm_pkg::STS_TIMEOUT;
                  state_nxt = mbrm_pkg::ST_STAT;
                end
              end
            end
            mbrm_pkg::REQ_BYTE: begin
              if (await_r) begin
                if (bytes_r < exp_m2) begin
                  crc_nxt = crc_f;
                end
                if (bytes_r == 8'd1) begin
                  rfunc_nxt = f_rx;
                end else if (bytes_r == 8'd2) begin
                  rcount_nxt = f_rx;
                end else if ((bytes_r >= 8'd3) && (bytes_r < exp_m2)) begin
                  if (bytes_r[0]) begin
                    pend_nxt = f_rx;
                  end else begin
                    mem_we = 1'b1;
                  end
                end
                if (bytes_r == exp_m2) begin
                  crc_lo_nxt = f_rx;
                end
                bytes_nxt = bytes_r + 8'd1;
                if (bytes_r == exp_m1) begin
                  await_nxt = 1'b0;
                  widx_nxt  = 6'd0;
                  state_nxt = mbrm_pkg::ST_STAT;
                  if (rfunc_r == (sfunc_r | mbrm_pkg::EXC_BIT)) begin
                    sts_nxt = mbrm_pkg::STS_EXCEPT;
                  end else if (rcount_r != {1'b0, sq_r, 1'b0}) begin
                    sts_nxt = mbrm_pkg::STS_LENGTH;
                  end else if ({f_rx, crc_lo_r} != crc_r) begin
                    sts_nxt = mbrm_pkg::STS_CRC;
                  end else begin
                    sts_nxt = mbrm_pkg::STS_OK;
                    if (sq_r != 6'd0) begin
                      state_nxt = mbrm_pkg::ST_WORDS;
                    end
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      mbrm_pkg::ST_SEND: begin
        if (o_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mbrm_pkg::KIND_TX;
          out_tx_nxt    = tx_sel;
          out_idx_nxt   = 6'd0;
          out_val_nxt   = 16'd0;
          out_sts_nxt   = mbrm_pkg::STS_OK;
          out_last_nxt  = (cnt_r == 3'd7);
          cnt_nxt       = cnt_r + 3'd1;
          if (cnt_r < 3'd6) begin
            crc_nxt = crc_f;
          end
          if (cnt_r == 3'd7) begin
            crc_nxt   = mbrm_pkg::CRC_INIT;
            state_nxt = mbrm_pkg::ST_IDLE;
          end
        end
      end
      mbrm_pkg::ST_WORDS: begin
        if (o_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mbrm_pkg::KIND_WORD;
          out_tx_nxt    = 8'd0;
          out_idx_nxt   = widx_r;
          out_val_nxt   = mem_q;
          out_sts_nxt   = mbrm_pkg::STS_OK;
          out_last_nxt  = 1'b0;
          widx_nxt      = widx_inc;
          if (widx_inc == sq_r) begin
            sts_nxt   = mbrm_pkg::STS_OK;
            state_nxt = mbrm_pkg::ST_STAT;
          end
        end
      end
      mbrm_pkg::ST_STAT: begin
        if (o_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mbrm_pkg::KIND_STATUS;
          out_tx_nxt    = 8'd0;
          out_idx_nxt   = 6'd0;
          out_val_nxt   = 16'd0;
          out_sts_nxt   = sts_r;
          out_last_nxt  = 1'b1;
          state_nxt     = mbrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbrm_pkg::ST_IDLE;
      await_r     <= 1'b0;
      sfunc_r     <= 8'd0;
      sq_r        <= 6'd0;
      bytes_r     <= 8'd0;
      rfunc_r     <= 8'd0;
      rcount_r    <= 8'd0;
      crc_r       <= mbrm_pkg::CRC_INIT;
      crc_lo_r    <= 8'd0;
      pend_r      <= 8'd0;
      tick_r      <= 32'd0;
      timeout_r   <= 32'd1000;
      cnt_r       <= 3'd0;
      widx_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      await_r     <= await_nxt;
      sfunc_r     <= sfunc_nxt;
      sq_r        <= sq_nxt;
      bytes_r     <= bytes_nxt;
      rfunc_r     <= rfunc_nxt;
      rcount_r    <= rcount_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      pend_r      <= pend_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slave_r    <= slave_nxt;
    start_r    <= start_nxt;
    sts_r      <= sts_nxt;
    out_kind_r <= out_kind_nxt;
    out_tx_r   <= out_tx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_sts_r  <= out_sts_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_sts_r, out_val_r, out_idx_r, out_tx_r};

  a_words_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrm_pkg::ST_WORDS) |-> (widx_r < sq_r))
    else $error("word index beyond reply quantity");

  a_bytes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (bytes_r < exp_len))
    else $error("reply byte count passed expected length");

  a_qty_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, sq_r} <= MAXQ))
    else $error("saved quantity above limit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == mbrm_pkg::KIND_STATUS)) |-> out_last_r)
    else $error("status item without last");

  a_send_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrm_pkg::ST_SEND) |-> (await_r && (bytes_r == 8'd0)))
    else $error("request sent without a fresh reply wait");

endmodule

// ===== tb/modbus_rtu_master_read_engine_test.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_master_read_engine_test
// Drives start requests, reply bytes and time ticks into the read engine.
// Every item the engine takes is fed to an engine predictor kept here.
// Its frame bytes, register words and statuses are compared in order with
// the result stream. A directed table comes first: idle noise, bad quantity,
// restart, zero quantity, exception and zero timeout. Random exchanges follow
// over several timeout settings and three idling regimes.
// ----------------------------------------------------------------------------
module modbus_rtu_master_read_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrm_pkg::*;

  localparam int          MAX_QTY     = 32;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [7:0]  FN_HOLDING  = 8'h03;
  localparam logic [7:0]  FN_INPUT    = 8'h04;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_STATUS} chk_e;
  typedef enum logic [1:0] {RX_LIT, RX_CRC_LO, RX_CRC_HI} rxsel_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [5:0]  qty;
    logic [7:0]  rx;
  } mb_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [5:0]  idx;
    logic [15:0] val;
    logic [2:0]  sts;
    logic        last;
  } mb_result_t;

  typedef struct packed {
    row_e        op;
    logic [1:0]  kind;
    rxsel_e      sel;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [5:0]  qty;
    logic [7:0]  rx;
    logic [31:0] cfg;
    chk_e        chk;
    logic [2:0]  sts;
  } plan_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data   = '0;

  // engine predictor state
  logic [31:0] tmo_limit = 32'd1000;
  bit          awaiting;
  logic [7:0]  want_func;
  logic [5:0]  want_qty;
  logic [7:0]  rx_count;
  logic [7:0]  got_func;
  logic [7:0]  got_count;
  logic [15:0] rx_crc;
  logic [7:0]  crc_low;
  logic [7:0]  word_high;
  logic [15:0] words [0:MAX_QTY-1];
  logic [31:0] tick_count;

  mb_result_t  step_results [$];
  mb_result_t  outputs_due [$];

  int          tx_idle_pct = 30;
  int          rx_idle_pct = 56;
  int unsigned cycles;
  int          mismatches;
  int          items_in;
  int          live_items;
  int          results_checked;
  int          settings_used;
  int          status_seen [0:7];

  plan_row_t plan [21] = '{
    '{ROW_ITEM, REQ_TICK,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'hFF, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_UNUSED, RX_LIT,    8'hFF, 8'hFF, 16'hFFFF, 6'd63, 8'hFF, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_START,  RX_LIT,    8'hFF, 8'hFF, 16'hFFFF, 6'd63, 8'h00, 32'd0, CHK_STATUS,
      STS_QTY},
    '{ROW_ITEM, REQ_START,  RX_LIT,    8'h05, 8'h03, 16'h0010, 6'd2,  8'h00, 32'd0, CHK_MODEL,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h05, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_START,  RX_LIT,    8'h01, 8'h03, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_MODEL,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h01, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h03, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_CRC_LO, 8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_CRC_HI, 8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_STATUS,
      STS_OK},
    '{ROW_ITEM, REQ_START,  RX_LIT,    8'hFF, 8'h04, 16'hFFFF, 6'd0,  8'h00, 32'd0, CHK_MODEL,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'hFF, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h84, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_CRC_LO, 8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_BYTE,   RX_CRC_HI, 8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_STATUS,
      STS_EXCEPT},
    '{ROW_CFG,  REQ_START,  RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_NONE,
      STS_OK},
    '{ROW_ITEM, REQ_START,  RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd32, 8'h00, 32'd0, CHK_MODEL,
      STS_OK},
    '{ROW_ITEM, REQ_TICK,   RX_LIT,    8'h00, 8'h00, 16'h0000, 6'd0,  8'h00, 32'd0, CHK_STATUS,
      STS_TIMEOUT}
  };

  modbus_rtu_master_read_engine #(
    .MAX_QTY(MAX_QTY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] tx,
                                     input logic [5:0] idx, input logic [15:0] val,
                                     input logic [2:0] sts, input logic last);
    step_results.push_back('{kind, tx, idx, val, sts, last});
  endfunction

  function automatic void close_run(input logic [2:0] sts);
    add_result(KIND_STATUS, 8'h00, 6'd0, 16'h0000, sts, 1'b1);
    awaiting = 1'b0;
  endfunction

  function automatic mb_item_t rand_item(input logic [1:0] kind);
    mb_item_t it;
    it.kind  = kind;
    it.slave = 8'($urandom_range(255));
    it.func  = 8'($urandom_range(255));
    it.addr  = 16'($urandom_range(65535));
    it.qty   = 6'($urandom_range(63));
    it.rx    = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic predict_engine(input mb_item_t it, output bit live);
    logic [7:0]  frame [0:7];
    logic [15:0] c;
    int          i;
    int          full;
    int          w;
    step_results.delete();
    live = (it.kind == REQ_START) ||
           (awaiting && (it.kind == REQ_BYTE || it.kind == REQ_TICK));
    if (it.kind == REQ_START) begin
      if (it.qty > MAX_QTY) begin
        close_run(STS_QTY);
      end else begin
        frame[0] = it.slave;
        frame[1] = it.func;
        frame[2] = it.addr[15:8];
        frame[3] = it.addr[7:0];
        frame[4] = 8'h00;
        frame[5] = {2'b00, it.qty};
        c = CRC_INIT;
        for (i = 0; i < 6; i++) c = crc16_byte(c, frame[i]);
        frame[6] = c[7:0];
        frame[7] = c[15:8];
        for (i = 0; i < 8; i++) add_result(KIND_TX, frame[i], 6'd0, 16'h0000, STS_OK, i == 7);
        awaiting   = 1'b1;
        want_func  = it.func;
        want_qty   = it.qty;
        rx_count   = '0;
        got_func   = '0;
        got_count  = '0;
        rx_crc     = CRC_INIT;
        crc_low    = '0;
        word_high  = '0;
        tick_count = '0;
      end
    end else if (awaiting && it.kind == REQ_TICK) begin
      tick_count = tick_count + 1;
      if (tick_count >= tmo_limit) close_run(STS_TIMEOUT);
    end else if (awaiting && it.kind == REQ_BYTE) begin
      full = 5 + 2 * want_qty;
      i    = rx_count;
      if (i < full - 2) rx_crc = crc16_byte(rx_crc, it.rx);
      if (i == 1) begin
        got_func = it.rx;
      end else if (i == 2) begin
        got_count = it.rx;
      end else if (i >= 3 && i < full - 2) begin
        if (((i - 3) & 1) == 0) begin
          word_high = it.rx;
        end else begin
          w = (i - 4) >> 1;
          if (w < MAX_QTY) words[w] = {word_high, it.rx};
        end
      end
      if (i == full - 2) crc_low = it.rx;
      rx_count = 8'(i + 1);
      if (i == full - 1) begin
        if (got_func == (want_func | EXC_BIT)) begin
          close_run(STS_EXCEPT);
        end else if (got_count != {1'b0, want_qty, 1'b0}) begin
          close_run(STS_LENGTH);
        end else if ({it.rx, crc_low} != rx_crc) begin
          close_run(STS_CRC);
        end else begin
          for (w = 0; w < want_qty; w++) add_result(KIND_WORD, 8'h00, w, words[w], STS_OK, 1'b0);
          close_run(STS_OK);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 20) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_item(input mb_item_t it, input chk_e chk, input logic [2:0] sts);
    bit live;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {2'b00, it.rx, it.qty, it.addr, it.func, it.slave};
    do @(posedge clk); while (!in_tready);
    predict_engine(it, live);
    items_in++;
    if (live) live_items++;
    case (chk)
      CHK_MODEL: foreach (step_results[k]) outputs_due.push_back(step_results[k]);
      CHK_STATUS: outputs_due.push_back('{KIND_STATUS, 8'h00, 6'd0, 16'h0000, sts, 1'b1});
      default: ;
    endcase
  endtask

  task automatic set_timeout(input logic [31:0] v);
    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tmo_limit = v;
    settings_used++;
  endtask

  task automatic run_exchange();
    mb_item_t    it;
    logic [15:0] c;
    logic [7:0]  b;
    logic [7:0]  fn;
    int          q;
    int          shape;
    int          full;
    int          len;
    int          k;
    int          n;
    bit          corrupt;
    k = $urandom_range(99);
    if (k < 60) q = $urandom_range(3);
    else if (k < 78) q = $urandom_range(16, 4);
    else if (k < 88) q = MAX_QTY;
    else q = $urandom_range(63, MAX_QTY + 1);
    k = $urandom_range(99);
    fn = (k < 55) ? FN_HOLDING : (k < 90) ? FN_INPUT : 8'($urandom_range(255));
    it = rand_item(REQ_START);
    it.qty  = q[5:0];
    it.func = fn;
    push_item(it, CHK_MODEL, STS_OK);
    if (q > MAX_QTY) return;
    full    = 5 + 2 * q;
    shape   = $urandom_range(99);
    corrupt = ($urandom_range(9) == 0);
    if (shape < 85) begin
      len = (shape < 70) ? full : $urandom_range(full - 1);
      c = CRC_INIT;
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 8) push_item(rand_item(REQ_TICK), CHK_MODEL, STS_OK);
        b = 8'($urandom_range(255));
        case (k)
          0: if ($urandom_range(9) < 8) b = it.slave;
          1: begin
            n = $urandom_range(99);
            if (n < 85) b = fn;
            else if (n < 95) b = fn | EXC_BIT;
          end
          2: if ($urandom_range(9) != 0) b = 8'(2 * q);
          default: begin
            if (k == full - 2) b = corrupt ? c[7:0] ^ 8'($urandom_range(255, 1)) : c[7:0];
            else if (k == full - 1) b = c[15:8];
          end
        endcase
        if (k < full - 2) c = crc16_byte(c, b);
        it = rand_item(REQ_BYTE);
        it.rx = b;
        push_item(it, CHK_MODEL, STS_OK);
      end
    end else if (shape < 93) begin
      n = (tmo_limit <= 40) ? int'(tmo_limit) : $urandom_range(40, 1);
      repeat (n) push_item(rand_item(REQ_TICK), CHK_MODEL, STS_OK);
      push_item(rand_item(REQ_BYTE), CHK_MODEL, STS_OK);
    end else begin
      repeat ($urandom_range(4, 1)) push_item(rand_item(2'($urandom_range(3, 1))), CHK_MODEL, STS_OK);
    end
  endtask

  always @(posedge clk) begin
    mb_result_t got;
    mb_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[13:8], out_tdata[29:14], out_tdata[32:30],
              out_tlast};
      results_checked++;
      if (got.kind == KIND_STATUS) status_seen[got.sts]++;
      if (outputs_due.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing outstanding", got.kind));
      end else begin
        want = outputs_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "kind %0d/%0d tx %h/%h index %0d/%0d value %h/%h status %0d/%0d last %0b/%0b",
            got.kind, want.kind, got.tx, want.tx, got.idx, want.idx, got.val, want.val,
            got.sts, want.sts, got.last, want.last));
      end
    end
  end

  initial begin : stimulus
    mb_item_t    it;
    logic [15:0] reply_crc;
    logic [31:0] v;
    int          r;
    int          ph;
    int          mark;
    reply_crc = CRC_INIT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < 21; r++) begin
      if (plan[r].op == ROW_CFG) begin
        set_timeout(plan[r].cfg);
      end else begin
        it.kind  = plan[r].kind;
        it.slave = plan[r].slave;
        it.func  = plan[r].func;
        it.addr  = plan[r].addr;
        it.qty   = plan[r].qty;
        it.rx    = (plan[r].sel == RX_CRC_LO) ? reply_crc[7:0] :
                   (plan[r].sel == RX_CRC_HI) ? reply_crc[15:8] : plan[r].rx;
        if (it.kind == REQ_START) reply_crc = CRC_INIT;
        else if (it.kind == REQ_BYTE && plan[r].sel == RX_LIT)
          reply_crc = crc16_byte(reply_crc, it.rx);
        push_item(it, plan[r].chk, plan[r].sts);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 56 : 0;
      rx_idle_pct = (ph < 2) ? 56 : (ph < 4) ? 30 : 0;
      case (ph)
        0: v = 32'd1;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'd6;
        5: v = 32'd8;
        default: v = $urandom_range(30, 2);
      endcase
      set_timeout(v);
      mark = live_items;
      while (live_items - mark < 25) run_exchange();
      // drop any pending run before the next setting
      it = rand_item(REQ_START);
      it.qty = 6'($urandom_range(63, MAX_QTY + 1));
      push_item(it, CHK_MODEL, STS_OK);
    end

    in_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d items (%0d reaching the engine), %0d results, %0d timeout settings",
             items_in, live_items, results_checked, settings_used);
    $display("final statuses ok %0d, timeout %0d, exception %0d, length %0d, crc %0d, qty %0d",
             status_seen[STS_OK], status_seen[STS_TIMEOUT], status_seen[STS_EXCEPT],
             status_seen[STS_LENGTH], status_seen[STS_CRC], status_seen[STS_QTY]);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
